@@ rtl/core/gdas_pkg.sv @@
// shared types, constants and calendar helpers for the date add/subtract core
package gdas_pkg;

  localparam logic [13:0] YearFirst = 14'd1582;
  localparam logic [13:0] YearLast  = 14'd9999;
  localparam logic [13:0] ModBase   = 14'd400;
  localparam logic [8:0]  ModLast   = 9'd399;
  localparam logic [2:0]  ModSteps  = 3'd4;

  typedef enum logic [0:0] {
    REQ_ADD = 1'b0,
    REQ_SUB = 1'b1
  } gdas_req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_FIX,
    ST_ADD_MON,
    ST_ADD_YEAR,
    ST_SUB_MON,
    ST_SUB_YEAR,
    ST_DONE
  } gdas_state_e;

  typedef struct packed {
    logic        req_type;
    logic [4:0]  day_in;
    logic [3:0]  month_in;
    logic [13:0] year_in;
    logic [15:0] day_count;
  } gdas_req_t;

  typedef struct packed {
    logic [4:0]  day_out;
    logic [3:0]  month_out;
    logic [13:0] year_out;
    logic        clamped;
  } gdas_rsp_t;

  // ylo: year mod 4, m400: year mod 400
  function automatic logic is_leap(input logic [1:0] ylo, input logic [8:0] m400);
    logic cent;
    cent = (m400 == 9'd0) || (m400 == 9'd100) || (m400 == 9'd200) || (m400 == 9'd300);
    return ((ylo == 2'd0) && !cent) || (m400 == 9'd0);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] year_len(input logic leap);
    return leap ? 9'd366 : 9'd365;
  endfunction

endpackage

@@ rtl/core/gdas_alu.sv @@
// shared subtract/compare unit used by the mod, month and year steps of the sequencer
module gdas_alu #(
  parameter int W = 16
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  output logic [W-1:0] diff_o,
  output logic         borrow_o
);

  logic [W:0] full;

  assign full     = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o   = full[W-1:0];
  assign borrow_o = full[W];

endmodule

@@ rtl/core/gdas_seq.sv @@
// sequencer and date registers: steps whole months and whole years through the shared unit
module gdas_seq
  import gdas_pkg::*;
#(
  parameter int CntW = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  input  gdas_req_t req_i,
  output logic      busy_o,
  output logic      res_valid_o,
  input  logic      res_take_i,
  output gdas_rsp_t res_o
);

  localparam int AluW = (CntW > 14) ? CntW : 14;

  gdas_state_e state_q, state_d;
  logic            sub_q, sub_d;
  logic [4:0]      d_q, d_d;
  logic [3:0]      m_q, m_d;
  logic [13:0]     y_q, y_d;
  logic [CntW-1:0] c_q, c_d;
  logic [13:0]     r_q, r_d;
  logic [8:0]      m400_q, m400_d;
  logic [2:0]      k_q, k_d;
  logic            flag_q, flag_d;

  logic [AluW-1:0] alu_a, alu_b, alu_diff;
  logic            alu_borrow;

  logic            leap;
  logic [4:0]      len, avail, prev_len;
  logic [5:0]      step_w;
  logic [8:0]      m400_inc, m400_dec;
  logic [3:0]      m_in;
  logic [13:0]     y_in;
  logic [13:0]     mod_sub;

  gdas_alu #(.W(AluW)) u_alu (
    .a_i      (alu_a),
    .b_i      (alu_b),
    .diff_o   (alu_diff),
    .borrow_o (alu_borrow)
  );

  assign leap     = is_leap(y_q[1:0], m400_q);
  assign len      = month_len(m_q, leap);
  assign avail    = len - d_q;
  assign step_w   = {1'b0, avail} + 6'd1;
  assign prev_len = month_len(m_q - 4'd1, leap);
  assign m400_inc = (m400_q == ModLast) ? 9'd0 : m400_q + 9'd1;
  assign m400_dec = (m400_q == 9'd0) ? ModLast : m400_q - 9'd1;
  assign mod_sub  = 14'(ModBase << k_q);

  // input correction of month and year
  always_comb begin
    m_in = req_i.month_in;
    if (m_in < 4'd1) m_in = 4'd1;
    if (m_in > 4'd12) m_in = 4'd12;
    y_in = req_i.year_in;
    if (y_in < YearFirst) y_in = YearFirst;
    if (y_in > YearLast) y_in = YearLast;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sub_q  <= sub_d;
    d_q    <= d_d;
    m_q    <= m_d;
    y_q    <= y_d;
    c_q    <= c_d;
    r_q    <= r_d;
    m400_q <= m400_d;
    k_q    <= k_d;
    flag_q <= flag_d;
  end

  always_comb begin
    logic [4:0] fix_len;
    state_d = state_q;
    sub_d   = sub_q;
    d_d     = d_q;
    m_d     = m_q;
    y_d     = y_q;
    c_d     = c_q;
    r_d     = r_q;
    m400_d  = m400_q;
    k_d     = k_q;
    flag_d  = flag_q;
    alu_a   = '0;
    alu_b   = '0;
    fix_len = month_len(m_q, is_leap(y_q[1:0], r_q[8:0]));
    res_valid_o = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          sub_d   = req_i.req_type;
          d_d     = req_i.day_in;
          m_d     = m_in;
          y_d     = y_in;
          r_d     = y_in;
          c_d     = req_i.day_count[CntW-1:0];
          k_d     = ModSteps;
          flag_d  = 1'b0;
          state_d = ST_MOD;
        end
      end
      // year mod 400 by restoring subtraction of 400 << k
      ST_MOD: begin
        alu_a = AluW'(r_q);
        alu_b = AluW'(mod_sub);
        if (!alu_borrow) r_d = alu_diff[13:0];
        if (k_q == 3'd0) begin
          state_d = ST_FIX;
        end else begin
          k_d = k_q - 3'd1;
        end
      end
      ST_FIX: begin
        m400_d = r_q[8:0];
        if (d_q == 5'd0) begin
          d_d = 5'd1;
        end else if (d_q > fix_len) begin
          d_d = fix_len;
        end
        state_d = (sub_q == REQ_SUB) ? ST_SUB_MON : ST_ADD_MON;
      end
      ST_ADD_MON: begin
        alu_a = AluW'(c_q);
        alu_b = AluW'(step_w);
        if (alu_borrow) begin
          d_d     = d_q + c_q[4:0];
          state_d = ST_DONE;
        end else begin
          c_d = alu_diff[CntW-1:0];
          d_d = 5'd1;
          if (m_q == 4'd12) begin
            if (y_q == YearLast) begin
              d_d     = 5'd31;
              flag_d  = 1'b1;
              state_d = ST_DONE;
            end else begin
              m_d     = 4'd1;
              y_d     = y_q + 14'd1;
              m400_d  = m400_inc;
              state_d = ST_ADD_YEAR;
            end
          end else begin
            m_d = m_q + 4'd1;
          end
        end
      end
      // sitting on january 1st
      ST_ADD_YEAR: begin
        alu_a = AluW'(c_q);
        alu_b = AluW'(year_len(leap));
        if (alu_borrow) begin
          state_d = ST_ADD_MON;
        end else if (y_q == YearLast) begin
          d_d     = 5'd31;
          m_d     = 4'd12;
          flag_d  = 1'b1;
          state_d = ST_DONE;
        end else begin
          c_d    = alu_diff[CntW-1:0];
          y_d    = y_q + 14'd1;
          m400_d = m400_inc;
        end
      end
      ST_SUB_MON: begin
        alu_a = AluW'(c_q);
        alu_b = AluW'(d_q);
        if (alu_borrow) begin
          d_d     = d_q - c_q[4:0];
          state_d = ST_DONE;
        end else begin
          c_d = alu_diff[CntW-1:0];
          if (m_q == 4'd1) begin
            if (y_q == YearFirst) begin
              d_d     = 5'd1;
              flag_d  = 1'b1;
              state_d = ST_DONE;
            end else begin
              d_d     = 5'd31;
              m_d     = 4'd12;
              y_d     = y_q - 14'd1;
              m400_d  = m400_dec;
              state_d = ST_SUB_YEAR;
            end
          end else begin
            m_d = m_q - 4'd1;
            d_d = prev_len;
          end
        end
      end
      // sitting on december 31st
      ST_SUB_YEAR: begin
        alu_a = AluW'(c_q);
        alu_b = AluW'(year_len(leap));
        if (alu_borrow) begin
          state_d = ST_SUB_MON;
        end else if (y_q == YearFirst) begin
          d_d     = 5'd1;
          m_d     = 4'd1;
          flag_d  = 1'b1;
          state_d = ST_DONE;
        end else begin
          c_d    = alu_diff[CntW-1:0];
          y_d    = y_q - 14'd1;
          m400_d = m400_dec;
        end
      end
      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_take_i) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o              = (state_q != ST_IDLE);
  assign res_o.day_out       = d_q;
  assign res_o.month_out     = m_q;
  assign res_o.year_out      = y_q;
  assign res_o.clamped       = flag_q;

endmodule

@@ rtl/core/gregorian_date_add_sub_days_core.sv @@
// Gregorian date add/subtract days core. One transaction takes a start date, a day count
// and add/subtract; the result is the date that many days later or earlier within
// 1582-01-01 .. 9999-12-31, clamped to the nearer end with the clamped bit set when it
// would leave that span. Out-of-range input fields are corrected first (month to 1..12,
// year to 1582..9999, day to 1..month length). The core handles one transaction at a time
// and holds in_stall_o high while busy: setup (accept, five restoring subtraction steps to take
// the year mod 400, day correction), then one whole month or whole year per cycle stepped
// through the single shared subtractor, then the hand-off of the result to the output
// register. The output register lets the next transaction be accepted while a result
// waits.
module gregorian_date_add_sub_days_core
  import gdas_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  gdas_req_t in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output gdas_rsp_t out_data_o
);

  localparam int CntW = (COUNT_BITS < 16) ? COUNT_BITS : 16;

  logic      busy;
  logic      res_valid;
  logic      res_take;
  gdas_rsp_t res;

  logic      out_valid_q, out_valid_d;
  gdas_rsp_t out_q;

  gdas_seq #(.CntW(CntW)) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_i       (in_data_i),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res)
  );

  assign in_stall_o = busy;
  assign res_take   = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_take) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("core not busy after accepting a transaction");

  a_clamp_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.clamped) |->
      ((out_data_o.year_out == YearFirst && out_data_o.month_out == 4'd1 &&
        out_data_o.day_out == 5'd1) ||
       (out_data_o.year_out == YearLast && out_data_o.month_out == 4'd12 &&
        out_data_o.day_out == 5'd31)))
    else $error("clamped result not at an end of the span");

  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.month_out >= 4'd1 && out_data_o.month_out <= 4'd12 &&
                     out_data_o.day_out >= 5'd1 &&
                     out_data_o.year_out >= YearFirst && out_data_o.year_out <= YearLast))
    else $error("result date out of range");
`endif

endmodule

@@ tb/sv/gregorian_date_add_sub_days_core_test.sv @@
// testbench for the gregorian date add/subtract days core
module gregorian_date_add_sub_days_core_test;
  import gdas_pkg::*;

  localparam int CountBits = 16;

  typedef struct {
    gdas_req_t rq;
    bit        known;
    gdas_rsp_t rsp;
  } date_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  gdas_req_t in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  gdas_rsp_t out_data_o;

  gdas_rsp_t expected_dates[$];
  date_row_t directed_rows[$];
  int        mismatch_count = 0;
  bit        calm = 1'b0;

  gregorian_date_add_sub_days_core #(
    .COUNT_BITS(CountBits)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // calendar arithmetic for the predictor
  function automatic bit leap_year(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
    int unsigned len;
    case (m)
      2:       len = leap_year(y) ? 29 : 28;
      4, 6, 9, 11: len = 30;
      default: len = 31;
    endcase
    return len;
  endfunction

  // days from the first day of year one to january 1st of year y
  function automatic int unsigned days_to_jan1(int unsigned y);
    int unsigned p;
    p = y - 1;
    return 365 * p + p / 4 - p / 100 + p / 400;
  endfunction

  // day number counted from 1582-01-01
  function automatic int unsigned date_index(int unsigned d, int unsigned m, int unsigned y);
    int unsigned s;
    s = days_to_jan1(y) - days_to_jan1(YearFirst);
    for (int unsigned k = 1; k < m; k++) s += days_in_month(k, y);
    return s + d - 1;
  endfunction

  function automatic gdas_rsp_t predict_shifted_date(gdas_req_t rq);
    int unsigned d, m, y, cnt, here, top, dest, first, rest;
    gdas_rsp_t rsp;
    d = rq.day_in;
    m = rq.month_in;
    y = rq.year_in;
    cnt = rq.day_count & ((1 << CountBits) - 1);
    rsp.clamped = 1'b0;
    // out-of-range fields are pulled into range first
    if (m < 1) m = 1;
    if (m > 12) m = 12;
    if (y < YearFirst) y = YearFirst;
    if (y > YearLast) y = YearLast;
    if (d < 1) d = 1;
    if (d > days_in_month(m, y)) d = days_in_month(m, y);
    here = date_index(d, m, y);
    top = date_index(31, 12, YearLast);
    if (rq.req_type == REQ_SUB) begin
      if (cnt > here) begin
        dest = 0;
        rsp.clamped = 1'b1;
      end else begin
        dest = here - cnt;
      end
    end else if (cnt > top - here) begin
      dest = top;
      rsp.clamped = 1'b1;
    end else begin
      dest = here + cnt;
    end
    first = days_to_jan1(YearFirst);
    y = YearFirst + dest / 366;
    while (days_to_jan1(y + 1) - first <= dest) y++;
    rest = dest - (days_to_jan1(y) - first);
    m = 1;
    while (m < 12 && rest >= days_in_month(m, y)) begin
      rest -= days_in_month(m, y);
      m++;
    end
    rsp.day_out = 5'(rest + 1);
    rsp.month_out = 4'(m);
    rsp.year_out = 14'(y);
    return rsp;
  endfunction

  function automatic date_row_t row(gdas_req_e op, int d, int m, int y, int cnt,
                                    bit known = 1'b0, int rd = 0, int rm = 0, int ry = 0,
                                    bit cl = 1'b0);
    date_row_t r;
    r.rq.req_type = op;
    r.rq.day_in = 5'(d);
    r.rq.month_in = 4'(m);
    r.rq.year_in = 14'(y);
    r.rq.day_count = 16'(cnt);
    r.known = known;
    r.rsp.day_out = 5'(rd);
    r.rsp.month_out = 4'(rm);
    r.rsp.year_out = 14'(ry);
    r.rsp.clamped = cl;
    return r;
  endfunction

  // mostly short pauses, now and then a long one
  function automatic int unsigned pick_idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 12);
    return $urandom_range(40, 300);
  endfunction

  function automatic gdas_req_t random_date_req();
    gdas_req_t rq;
    int unsigned kind, y, m;
    kind = $urandom_range(0, 99);
    rq.req_type = $urandom_range(0, 1) ? REQ_SUB : REQ_ADD;
    // bias some years toward the ends of the span so clamping happens often
    if (kind < 8) y = $urandom_range(0, 16383);
    else if (kind < 22) y = $urandom_range(1582, 1760);
    else if (kind < 36) y = $urandom_range(9820, 9999);
    else y = $urandom_range(1582, 9999);
    m = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 12);
    rq.year_in = 14'(y);
    rq.month_in = 4'(m);
    if (y < YearFirst) y = YearFirst;
    if (y > YearLast) y = YearLast;
    if (m < 1) m = 1;
    if (m > 12) m = 12;
    if ($urandom_range(0, 9) == 0) rq.day_in = 5'($urandom_range(0, 31));
    else rq.day_in = 5'($urandom_range(1, days_in_month(m, y)));
    case ($urandom_range(0, 3))
      0:       rq.day_count = 16'($urandom_range(0, 400));
      1:       rq.day_count = 16'($urandom_range(0, 4000));
      default: rq.day_count = 16'($urandom_range(0, 65535));
    endcase
    return rq;
  endfunction

  task automatic send_request(gdas_req_t rq, bit known, gdas_rsp_t rsp);
    int unsigned gap;
    gap = (calm || $urandom_range(0, 1) == 0) ? 0 : pick_idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= rq;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_dates.push_back(known ? rsp : predict_shifted_date(rq));
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_dates.size() != 0) @(posedge clk_i);
  endtask

  task automatic compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // receiver side stalls
  initial begin
    int unsigned hold;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 3) == 0) begin
        hold = pick_idle_len();
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : check_results
    gdas_rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_dates.size() == 0) begin
        $error("result transaction with nothing expected: %p", out_data_o);
        mismatch_count++;
      end else begin
        want = expected_dates.pop_front();
        compare_field("day_out", want.day_out, out_data_o.day_out);
        compare_field("month_out", want.month_out, out_data_o.month_out);
        compare_field("year_out", want.year_out, out_data_o.year_out);
        compare_field("clamped", want.clamped, out_data_o.clamped);
      end
    end
  end

  initial begin
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;

    // edges of the span, leap rules and field corrections
    directed_rows.push_back(row(REQ_ADD, 1, 1, 1582, 0, 1, 1, 1, 1582, 0));
    directed_rows.push_back(row(REQ_SUB, 1, 1, 1582, 1, 1, 1, 1, 1582, 1));
    directed_rows.push_back(row(REQ_SUB, 2, 1, 1582, 1, 1, 1, 1, 1582, 0));
    directed_rows.push_back(row(REQ_SUB, 31, 12, 1582, 364, 1, 1, 1, 1582, 0));
    directed_rows.push_back(row(REQ_SUB, 31, 12, 1582, 365, 1, 1, 1, 1582, 1));
    directed_rows.push_back(row(REQ_ADD, 30, 12, 9999, 1, 1, 31, 12, 9999, 0));
    directed_rows.push_back(row(REQ_ADD, 30, 12, 9999, 2, 1, 31, 12, 9999, 1));
    directed_rows.push_back(row(REQ_ADD, 31, 12, 9999, 65535, 1, 31, 12, 9999, 1));
    directed_rows.push_back(row(REQ_SUB, 31, 12, 9999, 65535));
    directed_rows.push_back(row(REQ_ADD, 1, 1, 1582, 65535));
    directed_rows.push_back(row(REQ_ADD, 31, 12, 1999, 1, 1, 1, 1, 2000, 0));
    directed_rows.push_back(row(REQ_ADD, 28, 2, 2000, 1, 1, 29, 2, 2000, 0));
    directed_rows.push_back(row(REQ_ADD, 28, 2, 2100, 1, 1, 1, 3, 2100, 0));
    directed_rows.push_back(row(REQ_SUB, 1, 3, 2000, 1, 1, 29, 2, 2000, 0));
    directed_rows.push_back(row(REQ_ADD, 28, 2, 1600, 1, 1, 29, 2, 1600, 0));
    directed_rows.push_back(row(REQ_ADD, 15, 0, 2000, 0, 1, 15, 1, 2000, 0));
    directed_rows.push_back(row(REQ_ADD, 31, 15, 2001, 0, 1, 31, 12, 2001, 0));
    directed_rows.push_back(row(REQ_ADD, 10, 5, 0, 0, 1, 10, 5, 1582, 0));
    directed_rows.push_back(row(REQ_ADD, 1, 1, 16383, 0, 1, 1, 1, 9999, 0));
    directed_rows.push_back(row(REQ_ADD, 0, 3, 2023, 0, 1, 1, 3, 2023, 0));
    directed_rows.push_back(row(REQ_ADD, 31, 2, 2000, 0, 1, 29, 2, 2000, 0));
    directed_rows.push_back(row(REQ_ADD, 31, 2, 1900, 0, 1, 28, 2, 1900, 0));
    directed_rows.push_back(row(REQ_SUB, 31, 4, 2023, 0, 1, 30, 4, 2023, 0));
    directed_rows.push_back(row(REQ_SUB, 31, 15, 16383, 65535));
    directed_rows.push_back(row(REQ_SUB, 4, 7, 2024, 1000));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      send_request(directed_rows[i].rq, directed_rows[i].known, directed_rows[i].rsp);
    drain_results();

    for (int i = 0; i < 425; i++) begin
      calm = (i >= 300 && i < 360);
      if (i == 200) drain_results();
      send_request(random_date_req(), 1'b0, '0);
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    while (expected_dates.size() != 0) @(posedge clk_i);
    repeat (250) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("gregorian_date_add_sub_days_core_test: done, clean");
    end else begin
      $display("gregorian_date_add_sub_days_core_test: done, errors");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("gregorian_date_add_sub_days_core_test: done, errors");
    $finish;
  end

endmodule
